[rtl/pox_pkg.sv]
// Package for the pulse oximeter core: widths, register indexes, reset values,
// SpO2 fit constants and the state types of the back end.
// No dependencies.
package pox_pkg;

    localparam int SAMPLE_WIDTH_DEF = 12;
    localparam int COUNT_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH      = 2;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SPO2_W     = 7;
    localparam int BPM_W      = 16;
    localparam int RATIO_W    = 16;
    localparam int RATIO_FRAC = 12;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_PERIOD = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BPM_SCALE  = 8'd1;

    localparam logic [CFG_DATA_W-1:0] MIN_PERIOD_RST = 16'd100;
    localparam logic [CFG_DATA_W-1:0] BPM_SCALE_RST  = 16'd30000;

    localparam logic [RATIO_W-1:0] Q_ONE      = 16'd4096;
    localparam logic [RATIO_W-1:0] Q_LOW_MAX  = 16'd1638;
    localparam logic [RATIO_W-1:0] Q_HIGH_MIN = 16'd13927;

    localparam logic [19:0] LIN_BASE  = 20'd450560;
    localparam logic [4:0]  LIN_SLOPE = 5'd25;
    localparam logic [25:0] FIT_BASE  = 26'd49324032;
    localparam logic [11:0] FIT_SLOPE = 12'd3542;
    localparam int          FIT_SHIFT = 14;
    localparam int          FIT_HI_W  = 12;
    // Division by 25 is a multiply by 2622 and a 16-bit shift, exact below 4096.
    localparam logic [FIT_HI_W-1:0] FIT_RECIP    = 12'd2622;
    localparam int                  FIT_RECIP_SH = 16;

    localparam logic [SPO2_W-1:0] SPO2_AT_ONE = 7'd85;
    localparam logic [SPO2_W-1:0] SPO2_MAX    = 7'd100;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL,
        BK_RATIO,
        BK_RDIV,
        BK_FIT,
        BK_FIT2,
        BK_BPM,
        BK_BDIV,
        BK_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        FIT_ONE,
        FIT_ZERO,
        FIT_LIN,
        FIT_CURVE
    } t_fit_cls;

endpackage

[rtl/pox_if.sv]
// Channel interfaces of the pulse oximeter core: sample input, register
// write port and result output. Depends on pox_pkg.
interface pox_in_if #(
    parameter int SW = 12
) ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] red_ac;
    logic signed [SW-1:0] ir_ac;
    logic        [SW-1:0] red_dc;
    logic        [SW-1:0] ir_dc;

    modport source (output valid, red_ac, ir_ac, red_dc, ir_dc, input ready);
    modport sink   (input valid, red_ac, ir_ac, red_dc, ir_dc, output ready);
endinterface

interface pox_cfg_if import pox_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

interface pox_out_if import pox_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SPO2_W-1:0] spo2_percent;
    logic [BPM_W-1:0]  pulse_bpm;
    logic              updated;

    modport source (output valid, spo2_percent, pulse_bpm, updated, input ready);
    modport sink   (input valid, spo2_percent, pulse_bpm, updated, output ready);
endinterface

[rtl/pox_front.sv]
// Front end: register file, peak tracking, falling-edge period detection and
// classification of each sample into a job for the back end. Depends on pox_pkg.
module pox_front import pox_pkg::*; #(
    parameter int SW = SAMPLE_WIDTH_DEF,
    parameter int CW = COUNT_WIDTH_DEF,
    parameter int JOB_W = 1 + 4 * SW + CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pox_in_if.sink                i_smp,
    pox_cfg_if.sink               i_cfg,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output logic [JOB_W-1:0]      o_job,
    output logic [CFG_DATA_W-1:0] o_bpm_scale
);

    localparam int CMP_W = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

    logic signed [SW-1:0]   r_red_max, r_red_min, r_ir_max, r_ir_min, r_prev;
    logic signed [SW-1:0]   n_red_max, n_red_min, n_ir_max, n_ir_min;
    logic        [CW-1:0]   r_cnt, n_cnt, r_period, n_period;
    logic [CFG_DATA_W-1:0]  r_min_period, r_bpm_scale;
    logic signed [SW-1:0]   w_rac, w_iac;
    logic                   w_edge, w_fire, w_upd;
    logic        [SW:0]     w_dr, w_di;
    logic        [SW-1:0]   w_vpp_r, w_vpp_i;

    assign w_rac  = i_smp.red_ac;
    assign w_iac  = i_smp.ir_ac;
    assign w_fire = i_smp.valid && i_job_ready;
    assign w_edge = (w_rac[SW-1] || (w_rac == '0)) && !r_prev[SW-1] && (r_prev != '0);

    always_comb begin
        n_red_max = (w_rac > r_red_max) ? w_rac : r_red_max;
        n_red_min = (w_rac < r_red_min) ? w_rac : r_red_min;
        n_ir_max  = (w_iac > r_ir_max)  ? w_iac : r_ir_max;
        n_ir_min  = (w_iac < r_ir_min)  ? w_iac : r_ir_min;
        n_period  = r_period;
        n_cnt     = (r_cnt != '1) ? CW'(r_cnt + 1'b1) : r_cnt;
        if (w_edge) begin
            n_red_max = w_rac;
            n_red_min = w_rac;
            n_ir_max  = w_iac;
            n_ir_min  = w_iac;
            n_period  = r_cnt;
            n_cnt     = CW'(1);
        end
    end

    assign w_dr    = {n_red_max[SW-1], n_red_max} - {n_red_min[SW-1], n_red_min};
    assign w_di    = {n_ir_max[SW-1], n_ir_max} - {n_ir_min[SW-1], n_ir_min};
    assign w_vpp_r = w_dr[SW] ? '0 : w_dr[SW-1:0];
    assign w_vpp_i = w_di[SW] ? '0 : w_di[SW-1:0];
    assign w_upd   = (CMP_W'(n_period) >= CMP_W'(r_min_period)) && (w_vpp_r != '0);

    assign i_smp.ready = i_job_ready;
    assign o_job_valid = i_smp.valid;
    assign o_job       = {w_upd, w_vpp_r, w_vpp_i, i_smp.red_dc, i_smp.ir_dc, n_period};
    assign i_cfg.ready = 1'b1;
    assign o_bpm_scale = r_bpm_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST;
            r_bpm_scale  <= BPM_SCALE_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.addr == CFG_MIN_PERIOD) begin
                r_min_period <= i_cfg.data;
            end
            if (i_cfg.addr == CFG_BPM_SCALE) begin
                r_bpm_scale <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_max <= '0;
            r_red_min <= '0;
            r_ir_max  <= '0;
            r_ir_min  <= '0;
            r_prev    <= '0;
            r_cnt     <= '0;
            r_period  <= '0;
        end else if (w_fire) begin
            r_red_max <= n_red_max;
            r_red_min <= n_red_min;
            r_ir_max  <= n_ir_max;
            r_ir_min  <= n_ir_min;
            r_prev    <= w_rac;
            r_cnt     <= n_cnt;
            r_period  <= n_period;
        end
    end

endmodule

[rtl/pox_queue.sv]
// Small first-in first-out job queue between the front and back ends.
// Depends on pox_pkg.
module pox_queue import pox_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_valid,
    output logic         o_push_ready,
    input  logic [W-1:0] i_push_data,
    output logic         o_pop_valid,
    input  logic         i_pop_ready,
    output logic [W-1:0] o_pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr + 1'b1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd + 1'b1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= CNT_W'(r_cnt + 1'b1);
            end else if (w_pop && !w_push) begin
                r_cnt <= CNT_W'(r_cnt - 1'b1);
            end
        end
    end

endmodule

[rtl/pox_back.sv]
// Back end: ratio-of-ratios, SpO2 fit and pulse rate, using one shared
// shift-subtract divider, with the held results and the output beat. Depends on pox_pkg.
module pox_back import pox_pkg::*; #(
    parameter int SW = SAMPLE_WIDTH_DEF,
    parameter int CW = COUNT_WIDTH_DEF,
    parameter int JOB_W = 1 + 4 * SW + CW
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    output logic                  o_job_ready,
    input  logic [JOB_W-1:0]      i_job,
    input  logic [CFG_DATA_W-1:0] i_bpm_scale,
    pox_out_if.source             o_res
);

    localparam int DW     = (2 * SW > CW) ? 2 * SW : CW;
    localparam int QW     = BPM_W;
    localparam int STEP_W = $clog2(QW);
    localparam int SAT_SH = QW - RATIO_FRAC;

    t_back_state          r_state, n_state;
    t_fit_cls             r_cls, w_cls;
    logic [SW-1:0]        r_vpp_r, r_vpp_i, r_rdc, r_idc;
    logic [CW-1:0]        r_period;
    logic [DW-1:0]        r_num, r_den, r_rem, r_div;
    logic [QW-1:0]        r_quo;
    logic [STEP_W-1:0]    r_step;
    logic [19:0]          r_lin;
    logic                 r_fit_neg;
    logic [FIT_HI_W-1:0]  r_fit_hi;
    logic [SPO2_W-1:0]    r_spo2;
    logic [BPM_W-1:0]     r_bpm;
    logic                 r_upd;

    logic [2*SW-1:0]      w_num, w_den;
    logic [DW:0]          w_trial, w_diff;
    logic                 w_ge, w_last, w_sat;
    logic [DW-1:0]        n_rem;
    logic [QW-1:0]        n_quo;
    logic [20:0]          w_lin_prod;
    logic [19:0]          w_lin;
    logic [27:0]          w_fit_prod, w_fit_diff;
    logic [2*FIT_HI_W-1:0] w_fit_q;

    assign w_num = r_vpp_r * r_idc;
    assign w_den = r_vpp_i * r_rdc;
    assign w_sat = {{SAT_SH{1'b0}}, r_num} >= {r_den, {SAT_SH{1'b0}}};

    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = !w_diff[DW];
    assign n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    assign n_quo   = {r_quo[QW-2:0], w_ge};
    assign w_last  = (r_step == STEP_W'(QW - 1));

    assign w_lin_prod = LIN_SLOPE * r_quo;
    assign w_lin      = LIN_BASE - w_lin_prod[19:0];
    assign w_fit_prod = FIT_SLOPE * r_quo;
    assign w_fit_diff = {2'b00, FIT_BASE} - w_fit_prod;
    assign w_fit_q    = r_fit_hi * FIT_RECIP;

    always_comb begin
        if (r_quo == Q_ONE) begin
            w_cls = FIT_ONE;
        end else if (r_quo <= Q_LOW_MAX) begin
            w_cls = FIT_ZERO;
        end else if (r_quo < Q_ONE) begin
            w_cls = FIT_LIN;
        end else if (r_quo >= Q_HIGH_MIN) begin
            w_cls = FIT_ZERO;
        end else begin
            w_cls = FIT_CURVE;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_job_ready = 1'b0;
        o_res.valid = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_state = i_job[JOB_W-1] ? BK_MUL : BK_OUT;
                end
            end
            BK_MUL:   n_state = BK_RATIO;
            BK_RATIO: begin
                if (r_den == '0) begin
                    n_state = BK_BPM;
                end else if (w_sat) begin
                    n_state = BK_FIT;
                end else begin
                    n_state = BK_RDIV;
                end
            end
            BK_RDIV:  n_state = w_last ? BK_FIT : BK_RDIV;
            BK_FIT:   n_state = BK_FIT2;
            BK_FIT2:  n_state = BK_BPM;
            BK_BPM:   n_state = (r_period == '0) ? BK_OUT : BK_BDIV;
            BK_BDIV:  n_state = w_last ? BK_OUT : BK_BDIV;
            BK_OUT: begin
                o_res.valid = 1'b1;
                if (o_res.ready) begin
                    n_state = BK_IDLE;
                end
            end
            default:  n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spo2 <= '0;
            r_bpm  <= '0;
            r_upd  <= 1'b0;
        end else begin
            case (r_state)
                BK_IDLE: begin
                    if (i_job_valid) begin
                        r_upd <= i_job[JOB_W-1];
                    end
                end
                BK_RATIO: begin
                    if (r_den == '0) begin
                        r_spo2 <= '0;
                    end
                end
                BK_FIT2: begin
                    case (r_cls)
                        FIT_ONE:   r_spo2 <= SPO2_AT_ONE;
                        FIT_LIN:   r_spo2 <= r_lin[RATIO_FRAC +: SPO2_W];
                        FIT_CURVE: r_spo2 <= r_fit_neg ? '0 : w_fit_q[FIT_RECIP_SH +: SPO2_W];
                        default:   r_spo2 <= '0;
                    endcase
                end
                BK_BPM: begin
                    if (r_period == '0) begin
                        r_bpm <= '0;
                    end
                end
                BK_BDIV: begin
                    if (w_last) begin
                        r_bpm <= n_quo;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                {r_vpp_r, r_vpp_i, r_rdc, r_idc, r_period} <= i_job[JOB_W-2:0];
            end
            BK_MUL: begin
                r_num <= DW'(w_num);
                r_den <= DW'(w_den);
            end
            BK_RATIO: begin
                r_step <= '0;
                r_div  <= r_den;
                if (w_sat) begin
                    r_quo <= '1;
                end else begin
                    r_rem <= r_num >> SAT_SH;
                    r_quo <= {r_num[SAT_SH-1:0], {RATIO_FRAC{1'b0}}};
                end
            end
            BK_FIT: begin
                r_cls     <= w_cls;
                r_lin     <= w_lin;
                r_fit_neg <= w_fit_diff[27];
                r_fit_hi  <= w_fit_diff[FIT_SHIFT +: FIT_HI_W];
            end
            BK_BPM: begin
                r_step <= '0;
                r_rem  <= '0;
                r_quo  <= i_bpm_scale;
                r_div  <= DW'(r_period);
            end
            BK_RDIV, BK_BDIV: begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_step <= STEP_W'(r_step + 1'b1);
            end
            default: begin
            end
        endcase
    end

    assign o_res.spo2_percent = r_spo2;
    assign o_res.pulse_bpm    = r_bpm;
    assign o_res.updated      = r_upd;

endmodule

[rtl/pulse_oximeter_spo2_bpm_core.sv]
// Pulse oximeter core: one result beat for every accepted sample beat, carrying the
// held SpO2 and pulse rate and a flag for samples that refreshed them. A sample that
// refreshes the results runs at most two 16-step shift-subtract divisions (ratio of
// ratios, pulse) on one shared divider, with the SpO2 curve finished by a reciprocal
// multiply; any other sample goes straight to the output beat. Output stalls hold the
// back end in its output beat. The front end takes samples while the two-entry job
// queue has room, so input and output stall independently.
// Depends on pox_pkg, pox_if, pox_front, pox_queue and pox_back.
module pulse_oximeter_spo2_bpm_core import pox_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pox_in_if.sink    i_smp,
    pox_cfg_if.sink   i_cfg,
    pox_out_if.source o_res
);

    localparam int JOB_W = 1 + 4 * SAMPLE_WIDTH + COUNT_WIDTH;

    logic                  w_fq_valid, w_fq_ready, w_qb_valid, w_qb_ready;
    logic [JOB_W-1:0]      w_fq_job, w_qb_job;
    logic [CFG_DATA_W-1:0] w_bpm_scale;

    pox_front #(
        .SW    (SAMPLE_WIDTH),
        .CW    (COUNT_WIDTH),
        .JOB_W (JOB_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smp       (i_smp),
        .i_cfg       (i_cfg),
        .o_job_valid (w_fq_valid),
        .i_job_ready (w_fq_ready),
        .o_job       (w_fq_job),
        .o_bpm_scale (w_bpm_scale)
    );

    pox_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .o_push_ready (w_fq_ready),
        .i_push_data  (w_fq_job),
        .o_pop_valid  (w_qb_valid),
        .i_pop_ready  (w_qb_ready),
        .o_pop_data   (w_qb_job)
    );

    pox_back #(
        .SW    (SAMPLE_WIDTH),
        .CW    (COUNT_WIDTH),
        .JOB_W (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_qb_valid),
        .o_job_ready (w_qb_ready),
        .i_job       (w_qb_job),
        .i_bpm_scale (w_bpm_scale),
        .o_res       (o_res)
    );

endmodule

[rtl/pox_checker.sv]
// Port-level checker for the pulse oximeter core and its bind to the top level.
// Depends on pox_pkg and pulse_oximeter_spo2_bpm_core.
module pox_checker import pox_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [SPO2_W-1:0] i_spo2,
    input logic [BPM_W-1:0]  i_bpm,
    input logic              i_updated
);

    localparam int PEND_MAX = QUEUE_DEPTH + 1;

    logic [3:0]        r_pend;
    logic [SPO2_W-1:0] r_last_spo2;
    logic [BPM_W-1:0]  r_last_bpm;
    logic              w_in_fire, w_out_fire;

    assign w_in_fire  = i_in_valid && i_in_ready;
    assign w_out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_last_spo2 <= '0;
            r_last_bpm  <= '0;
        end else begin
            r_pend <= 4'(r_pend + {3'b000, w_in_fire} - {3'b000, w_out_fire});
            if (w_out_fire) begin
                r_last_spo2 <= i_spo2;
                r_last_bpm  <= i_bpm;
            end
        end
    end

    a_no_invented_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != '0))
        else $error("result beat without an outstanding sample");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 4'(PEND_MAX))
        else $error("more samples outstanding than the core can hold");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !i_updated) |-> (i_spo2 == r_last_spo2 && i_bpm == r_last_bpm))
        else $error("held results changed on a sample without an update");

    a_spo2_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_spo2 <= SPO2_MAX))
        else $error("SpO2 out of range");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_spo2) && $stable(i_bpm) && $stable(i_updated)))
        else $error("stalled result beat changed");

endmodule

bind pulse_oximeter_spo2_bpm_core pox_checker u_pox_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_spo2      (o_res.spo2_percent),
    .i_bpm       (o_res.pulse_bpm),
    .i_updated   (o_res.updated)
);
